>>> design/scatter_row_range_table_top_macros.svh
// Assertion macros of the scatter row range table top level.
`ifndef SCATTER_ROW_RANGE_TABLE_TOP_MACROS_SVH
`define SCATTER_ROW_RANGE_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SRRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Check that cons holds in the cycle after ante.
`define SRRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRRT_ASSERT_NOW(label, ante, cons, msg)
`define SRRT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/srrt_pkg.sv
// Types and constants of the scatter row range table.
`default_nettype none
package srrt_pkg;

   localparam int ROWS         = 4096;
   localparam int VALUE_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int ROW_BITS     = 12;
   localparam int ADDR_BITS    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_CMP_BITS = 21;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [ADDR_BITS-1:0]         row_addr_type;
   typedef logic [ROW_BITS-1:0]          row_type;

   localparam value_type ONE_VALUE = value_type'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      MODE_MERGE     = 2'd0,
      MODE_MERGE_ONE = 2'd1,
      MODE_READ      = 2'd2,
      MODE_CLEAR     = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] mode;
      row_type    row_index;
      value_type  sample_value;
      logic       sample_missing;
   } req_type;

   typedef struct packed {
      row_type   out_row;
      value_type row_min;
      value_type row_max;
      value_type row_nz_min;
      value_type row_nz_max;
      logic      nz_valid;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_MERGE,
      CMD_READ,
      CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type   op;
      logic         in_range;
      row_type      row;
      row_addr_type addr;
      value_type    value;
   } cmd_type;

   typedef struct packed {
      logic      nz_seen;
      value_type nz_max;
      value_type nz_min;
      value_type max;
      value_type min;
   } entry_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage
`default_nettype wire

>>> design/srrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module srrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/srrt_front.sv
// Front end: accept and classify transactions, queue commands for the back end.
`default_nettype none
module srrt_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  srrt_pkg::req_type       req_data,
   input  srrt_pkg::back_status_type status,
   output logic                    cmd_valid,
   output srrt_pkg::cmd_type       cmd,
   input  logic                    cmd_pop
);
   import srrt_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    cmd_in;
   logic       keep;
   logic       accept;
   logic       push;
   logic       pop;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Classify: drop NA values and out-of-range merges or clears here.
   always_comb begin
      cmd_in.row      = req_data.row_index;
      cmd_in.addr     = row_addr_type'(req_data.row_index);
      cmd_in.in_range = ROW_CMP_BITS'(req_data.row_index) < ROW_CMP_BITS'(ROWS);
      cmd_in.value    = req_data.sample_value;
      cmd_in.op       = CMD_MERGE;
      keep            = 1'b0;
      unique case (mode_type'(req_data.mode))
         MODE_MERGE: begin
            keep = cmd_in.in_range && !req_data.sample_missing;
         end
         MODE_MERGE_ONE: begin
            cmd_in.value = ONE_VALUE;
            keep         = cmd_in.in_range;
         end
         MODE_READ: begin
            cmd_in.op = CMD_READ;
            keep      = 1'b1;
         end
         MODE_CLEAR: begin
            cmd_in.op = CMD_CLEAR;
            keep      = cmd_in.in_range;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == 2'd2) || status.clearing;
   assign accept    = req_push && !req_full;
   assign push      = accept && keep;
   assign pop       = cmd_pop && (count_ff != 2'd0);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

>>> design/srrt_back.sv
// Back end: clear sweep, read-modify-write of the row table and result queue.
`default_nettype none
module srrt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  srrt_pkg::cmd_type         cmd,
   output logic                      cmd_pop,
   output srrt_pkg::back_status_type status,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output srrt_pkg::rsp_type         rsp_data
);
   import srrt_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;
   row_addr_type   clr_addr_ff, clr_addr_in;

   logic               wr_en;
   row_addr_type       wr_addr;
   entry_type          wr_data;
   logic               rd_en;
   logic [$bits(entry_type)-1:0] rd_data;
   entry_type          entry;
   entry_type          merged;
   rsp_type            rsp_in;
   logic               rsp_push;
   logic               rsp_take;

   rsp_type    rq_ff [2];
   logic       rq_wr_ptr_ff, rq_wr_ptr_in;
   logic       rq_rd_ptr_ff, rq_rd_ptr_in;
   logic [1:0] rq_count_ff, rq_count_in;

   srrt_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cmd.addr),
      .rd_data (rd_data)
   );

   assign entry = entry_type'(rd_data);

   // Merge one value into all four bounds.
   always_comb begin
      merged.min     = (cur_ff.value < entry.min) ? cur_ff.value : entry.min;
      merged.max     = (entry.max < cur_ff.value) ? cur_ff.value : entry.max;
      merged.nz_min  = (!entry.nz_seen || (cur_ff.value < entry.nz_min)) ?
                       cur_ff.value : entry.nz_min;
      merged.nz_max  = (!entry.nz_seen || (entry.nz_max < cur_ff.value)) ?
                       cur_ff.value : entry.nz_max;
      merged.nz_seen = 1'b1;
   end

   always_comb begin
      rsp_in.out_row    = cur_ff.row;
      rsp_in.row_min    = '0;
      rsp_in.row_max    = '0;
      rsp_in.row_nz_min = '0;
      rsp_in.row_nz_max = '0;
      rsp_in.nz_valid   = 1'b0;
      if (cur_ff.in_range) begin
         rsp_in.row_min  = entry.min;
         rsp_in.row_max  = entry.max;
         rsp_in.nz_valid = entry.nz_seen;
         if (entry.nz_seen) begin
            rsp_in.row_nz_min = entry.nz_min;
            rsp_in.row_nz_max = entry.nz_max;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      clr_addr_in = clr_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = cur_ff.addr;
      wr_data     = '0;
      rd_en       = 1'b0;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            if (clr_addr_ff == row_addr_type'(ROWS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + row_addr_type'(1);
            end
         end
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               rd_en    = 1'b1;
               cur_in   = cmd;
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            case (cur_ff.op)
               CMD_MERGE: begin
                  wr_en    = 1'b1;
                  wr_data  = merged;
                  state_in = BK_IDLE;
               end
               CMD_CLEAR: begin
                  wr_en    = 1'b1;
                  state_in = BK_IDLE;
               end
               CMD_READ: begin
                  if (rq_count_ff != 2'd2) begin
                     rsp_push = 1'b1;
                     state_in = BK_IDLE;
                  end
               end
               default: begin
                  state_in = BK_IDLE;
               end
            endcase
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign status.clearing = (state_ff == BK_CLEAR);

   // Result queue.
   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_data  = rq_ff[rq_rd_ptr_ff];

   always_comb begin
      rq_wr_ptr_in = rsp_push ? !rq_wr_ptr_ff : rq_wr_ptr_ff;
      rq_rd_ptr_in = rsp_take ? !rq_rd_ptr_ff : rq_rd_ptr_ff;
      rq_count_in  = rq_count_ff;
      if (rsp_push && !rsp_take) begin
         rq_count_in = rq_count_ff + 2'd1;
      end else if (rsp_take && !rsp_push) begin
         rq_count_in = rq_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ptr_ff <= 1'b0;
         rq_rd_ptr_ff <= 1'b0;
         rq_count_ff  <= 2'd0;
      end else begin
         rq_wr_ptr_ff <= rq_wr_ptr_in;
         rq_rd_ptr_ff <= rq_rd_ptr_in;
         rq_count_ff  <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wr_ptr_ff] <= rsp_in;
      end
   end

endmodule
`default_nettype wire

>>> design/scatter_row_range_table_top.sv
// Top level of the scatter row range table.
`default_nettype none
`include "scatter_row_range_table_top_macros.svh"
// Scatter row range table. Keeps, per row, the minimum and maximum (counting
// the implicit zero every row holds) and the nonzero minimum and maximum of
// signed Q16.16 values. A transaction on the req_ queue merges a value
// (mode 0, NA values dropped), merges the implicit value 1.0 (mode 1), reads
// a row (mode 2, one transaction on the rsp_ queue) or clears a row (mode 3).
// After reset the block sweeps the row memory once, one row per cycle, over
// all ROWS (4096) rows; req_full stays high during that sweep. Afterwards
// each merge, read or clear occupies the back end for a read-modify-write of
// the single row memory (registered read, then write), and the back end
// takes no new command until it is done; a read also waits while the result
// queue is full. Transactions that change nothing (NA values, out-of-range
// merges and clears) are dropped at the front in the cycle they are taken. A
// 2-entry command queue sits between front and back and a 2-entry result
// queue in front of rsp_, so input keeps flowing while a read result waits
// to be popped.
module scatter_row_range_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  srrt_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output srrt_pkg::rsp_type rsp_data
);
   import srrt_pkg::*;

   // Command handoff between front and back.
   logic            cmd_valid;
   cmd_type         cmd;
   logic            cmd_pop;
   back_status_type status;

   // Front: classify and queue transactions.
   srrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .status    (status),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Back: sweep, update the row memory and hold results.
   srrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .status    (status),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Hold off input while the memory sweep runs.
   `SRRT_ASSERT_NOW(a_full_while_clearing, status.clearing, req_full, "input open during sweep")
   // Drop no result: nothing can be waiting while the sweep runs.
   `SRRT_ASSERT_NOW(a_empty_while_clearing, status.clearing, rsp_empty, "result during sweep")
   // Advance the command queue only when it holds a command.
   `SRRT_ASSERT_NOW(a_pop_has_cmd, cmd_pop, cmd_valid, "back end popped an empty queue")
   // One command per read-modify-write: never take two in a row.
   `SRRT_ASSERT_NEXT(a_pop_spacing, cmd_pop, !cmd_pop, "back end took commands back to back")

endmodule
`default_nettype wire

>>> sim/tb_scatter_row_range_table_top.sv
// Self-checking testbench of the scatter row range table top level.
`default_nettype none
module tb_scatter_row_range_table_top;
   import srrt_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   // The slowest correct run adds up the sweep after reset, about 1900
   // transactions through the back end, random sender gaps and a heavily
   // stalled receiver. Allow several times that.
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int MAX_PRINTS     = 100;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   // Predicted row table, one entry per row, updated as each transaction is taken.
   value_type  row_lo    [ROWS];
   value_type  row_hi    [ROWS];
   value_type  row_nz_lo [ROWS];
   value_type  row_nz_hi [ROWS];
   logic       row_nz_seen [ROWS];

   // Row reads taken by the block whose results have not yet been popped.
   rsp_type    pending_row_reads [$];

   int         mismatch_count  = 0;
   int         reads_checked   = 0;
   int         items_sent      = 0;
   int         mode_count [4]  = '{default: 0};
   int         sender_idle_pct = 0;
   int         recv_idle_pct   = 0;
   int         hold_left       = 0;

   scatter_row_range_table_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Print one line per mismatch (up to a cap) and count every one of them.
   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("MISMATCH %s: expected %h, got %h", what, want, got);
   endtask

   // Fold one value into the four bounds of a row.
   task automatic fold_into_row(int unsigned r, value_type v);
      if (v < row_lo[r]) row_lo[r] = v;
      if (v > row_hi[r]) row_hi[r] = v;
      // The nonzero bounds compare against themselves, never against min/max.
      if (!row_nz_seen[r] || v < row_nz_lo[r]) row_nz_lo[r] = v;
      if (!row_nz_seen[r] || v > row_nz_hi[r]) row_nz_hi[r] = v;
      row_nz_seen[r] = 1'b1;
   endtask

   // Apply one taken transaction to the predicted table; queue a read result.
   task automatic update_row_table(req_type t);
      int unsigned r;
      logic        in_range;
      rsp_type     want;
      r        = t.row_index;
      in_range = (r < ROWS);
      case (mode_type'(t.mode))
         MODE_MERGE: begin
            // Drop NA values: they leave the row untouched.
            if (in_range && !t.sample_missing) fold_into_row(r, t.sample_value);
         end
         MODE_MERGE_ONE: begin
            if (in_range) fold_into_row(r, ONE_VALUE);
         end
         MODE_READ: begin
            want         = '0;
            want.out_row = t.row_index;
            if (in_range) begin
               want.row_min  = row_lo[r];
               want.row_max  = row_hi[r];
               want.nz_valid = row_nz_seen[r];
               // Hide the nonzero bounds until the row has seen a value.
               if (row_nz_seen[r]) begin
                  want.row_nz_min = row_nz_lo[r];
                  want.row_nz_max = row_nz_hi[r];
               end
            end
            pending_row_reads.push_back(want);
         end
         default: begin
            // Clear: every row keeps its implicit zero, so min and max go to 0.
            if (in_range) begin
               row_lo[r]      = '0;
               row_hi[r]      = '0;
               row_nz_seen[r] = 1'b0;
            end
         end
      endcase
   endtask

   // Compare one popped result, field by field, with the oldest predicted read.
   task automatic check_row_read(rsp_type got);
      rsp_type want;
      if (pending_row_reads.size() == 0) begin
         report_mismatch("result with no read outstanding, out_row", '0, 32'(got.out_row));
         return;
      end
      want = pending_row_reads.pop_front();
      reads_checked++;
      if (got.out_row !== want.out_row)
         report_mismatch("out_row", 32'(want.out_row), 32'(got.out_row));
      if (got.row_min !== want.row_min)
         report_mismatch("row_min", want.row_min, got.row_min);
      if (got.row_max !== want.row_max)
         report_mismatch("row_max", want.row_max, got.row_max);
      if (got.row_nz_min !== want.row_nz_min)
         report_mismatch("row_nz_min", want.row_nz_min, got.row_nz_min);
      if (got.row_nz_max !== want.row_nz_max)
         report_mismatch("row_nz_max", want.row_nz_max, got.row_nz_max);
      if (got.nz_valid !== want.nz_valid)
         report_mismatch("nz_valid", 32'(want.nz_valid), 32'(got.nz_valid));
   endtask

   // Result side: check each popped transaction, then decide the next pop.
   // A hold-off, when armed, is counted down here one cycle at a time.
   always @(posedge clock) begin
      if (rsp_pop && rsp_empty === 1'b0) check_row_read(rsp_data);
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic req_type make_req(mode_type m, row_type r, value_type v, logic miss);
      req_type t;
      t.mode           = m;
      t.row_index      = r;
      t.sample_value   = v;
      t.sample_missing = miss;
      return t;
   endfunction

   // Favor a handful of hot rows so repeated rows hit back-to-back updates.
   function automatic row_type pick_row();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return row_type'(2048);
         3, 4, 5: return row_type'($urandom_range(0, 15));
         default: return row_type'($urandom_range(0, ROWS - 1));
      endcase
   endfunction

   // Mix the extremes, 1.0 and -1.0, zero and small values around zero with full-range noise.
   function automatic value_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return value_type'(32'h7fff_ffff);
         1:       return value_type'(32'h8000_0000);
         2:       return ONE_VALUE;
         3:       return -ONE_VALUE;
         4:       return '0;
         5, 6:    return value_type'($urandom_range(0, 32'h0003_ffff)) -
                         value_type'(32'h0002_0000);
         default: return value_type'($urandom);
      endcase
   endfunction

   // Offer one transaction and hold it until the block takes it. Call at a
   // rising edge; return at the edge that took it with req_push still high,
   // so a following transaction goes out without a bubble. Each cycle before
   // the offer idles with probability sender_idle_pct percent.
   task automatic push_transaction(req_type t);
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_full !== 1'b0);
      update_row_table(t);
      items_sent++;
      mode_count[t.mode]++;
   endtask

   // Lower push and wait until every predicted read has come back.
   task automatic wait_reads_drained();
      req_push <= 1'b0;
      while (pending_row_reads.size() != 0) @(posedge clock);
   endtask

   // Extremes, every mode and the special cases, on a few chosen rows.
   task automatic test_directed_edges();
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      // Read rows straight out of the reset sweep: zero bounds, nothing valid.
      push_transaction(make_req(MODE_READ, '0, value_type'($urandom), 1'b1));
      push_transaction(make_req(MODE_READ, '1, value_type'($urandom), 1'b0));
      // Both value extremes into one row, back to back.
      push_transaction(make_req(MODE_MERGE, 12'd5, value_type'(32'h7fff_ffff), 1'b0));
      push_transaction(make_req(MODE_MERGE, 12'd5, value_type'(32'h8000_0000), 1'b0));
      push_transaction(make_req(MODE_READ, 12'd5, '0, 1'b0));
      // NA value leaves the row untouched.
      push_transaction(make_req(MODE_MERGE, 12'd7, value_type'(32'h0001_8000), 1'b1));
      push_transaction(make_req(MODE_READ, 12'd7, '1, 1'b1));
      // Implicit one ignores both the value and the NA flag.
      push_transaction(make_req(MODE_MERGE_ONE, 12'd7, value_type'(32'h8000_0000), 1'b1));
      push_transaction(make_req(MODE_READ, 12'd7, '0, 1'b0));
      // Implicit one above the nonzero max, then below the nonzero min.
      push_transaction(make_req(MODE_MERGE, 12'd9, value_type'(32'h0000_8000), 1'b0));
      push_transaction(make_req(MODE_MERGE_ONE, 12'd9, '0, 1'b0));
      push_transaction(make_req(MODE_READ, 12'd9, '0, 1'b0));
      push_transaction(make_req(MODE_MERGE, 12'd13, value_type'(32'h0003_0000), 1'b0));
      push_transaction(make_req(MODE_MERGE_ONE, 12'd13, '1, 1'b0));
      push_transaction(make_req(MODE_READ, 12'd13, '0, 1'b0));
      // A lone negative value: max keeps the implicit zero.
      push_transaction(make_req(MODE_MERGE, 12'd11, value_type'(32'hfffc_8000), 1'b0));
      push_transaction(make_req(MODE_READ, 12'd11, '0, 1'b0));
      // Clear a row with history, then read it and merge again.
      push_transaction(make_req(MODE_CLEAR, 12'd5, value_type'($urandom), 1'b1));
      push_transaction(make_req(MODE_READ, 12'd5, '0, 1'b0));
      push_transaction(make_req(MODE_MERGE, 12'd5, value_type'(32'h0000_0001), 1'b0));
      push_transaction(make_req(MODE_READ, 12'd5, '0, 1'b0));
      // Top row, and a zero value merged explicitly.
      push_transaction(make_req(MODE_MERGE, '1, value_type'(32'hffff_ffff), 1'b0));
      push_transaction(make_req(MODE_MERGE, '1, '0, 1'b0));
      push_transaction(make_req(MODE_READ, '1, '0, 1'b0));
      wait_reads_drained();
   endtask

   // Stall the result side for a long stretch while reads keep coming, so the
   // result and command queues fill and req_full holds the sender off.
   task automatic test_full_queue_stall();
      row_type r;
      sender_idle_pct = 0;
      hold_left       = 400;
      repeat (40) begin
         r = pick_row();
         if ($urandom_range(0, 2) == 0)
            push_transaction(make_req(MODE_MERGE, r, pick_sample(), 1'b0));
         push_transaction(make_req(MODE_READ, r, value_type'($urandom), 1'b0));
      end
      wait_reads_drained();
   endtask

   // Send a short burst, then pause until every read result is back.
   task automatic test_drain_pause();
      row_type r;
      sender_idle_pct = 0;
      recv_idle_pct   = 50;
      repeat (3) begin
         r = pick_row();
         push_transaction(make_req(MODE_CLEAR, r, value_type'($urandom), 1'b0));
         push_transaction(make_req(MODE_MERGE, r, pick_sample(), 1'b0));
         push_transaction(make_req(MODE_MERGE_ONE, r, value_type'($urandom), 1'b1));
         push_transaction(make_req(MODE_READ, r, '0, 1'b0));
         wait_reads_drained();
      end
   endtask

   // Random traffic: mostly clear/merge/read sequences on one row with random
   // content, the rest single transactions with every field random.
   task automatic test_random_phase(int count, int send_pct, int recv_pct);
      int      stop_at;
      int      k;
      row_type r;
      sender_idle_pct = send_pct;
      recv_idle_pct   = recv_pct;
      stop_at         = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 75) begin
            r = pick_row();
            if ($urandom_range(0, 1))
               push_transaction(make_req(MODE_CLEAR, r, value_type'($urandom),
                                         1'($urandom_range(0, 1))));
            repeat ($urandom_range(1, 6)) begin
               k = $urandom_range(0, 9);
               if (k < 2)
                  push_transaction(make_req(MODE_MERGE_ONE, r, value_type'($urandom),
                                            1'($urandom_range(0, 1))));
               else
                  push_transaction(make_req(MODE_MERGE, r, pick_sample(), 1'(k == 2)));
            end
            push_transaction(make_req(MODE_READ, r, value_type'($urandom),
                                      1'($urandom_range(0, 1))));
         end else begin
            push_transaction(make_req(mode_type'($urandom_range(0, 3)),
                                      row_type'($urandom_range(0, ROWS - 1)),
                                      value_type'($urandom), 1'($urandom_range(0, 1))));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ROWS; i++) begin
         row_lo[i]      = '0;
         row_hi[i]      = '0;
         row_nz_lo[i]   = '0;
         row_nz_hi[i]   = '0;
         row_nz_seen[i] = 1'b0;
      end
      // Hold reset at the start; the block then sweeps its memory with
      // req_full high, which the first transaction simply waits out.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_full_queue_stall();
      test_drain_pause();
      test_random_phase(600, 22, 69);
      test_random_phase(600, 69, 22);
      test_random_phase(600, 0, 0);

      // Drain every outstanding read, then give stray results time to show up.
      wait_reads_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transactions: %0d merges, %0d implicit ones, %0d reads, %0d clears.",
               items_sent, mode_count[MODE_MERGE], mode_count[MODE_MERGE_ONE],
               mode_count[MODE_READ], mode_count[MODE_CLEAR]);
      $display("Checked %0d row reads across three idle mixes and a full-queue stall.",
               reads_checked);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
